// ===== design/pms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pms_pkg;

   // Fixed field widths of the item and result ports.
   localparam int ACTION_W   = 1;
   localparam int POSITION_W = 5;
   localparam int WORD_W     = 10;
   localparam int LOG_W      = 16;
   localparam int SYMBOL_W   = 2;
   localparam int SCORE_W    = 21;
   localparam int COUNT_W    = 6;

   // Bits per nucleotide code inside the context word.
   localparam int SYMBOL_BITS = SYMBOL_W;

   // Default model dimensions.
   localparam int MAX_LENGTH_DEFAULT = 32;
   localparam int MAX_ORDER_DEFAULT  = 4;

   // Control register port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;
   localparam int ORDER_W    = 3;
   localparam int LENGTH_W   = 6;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH = 1'd1;

   // Register reset values.
   localparam logic [ORDER_W-1:0]  ORDER_RESET  = 3'd2;
   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 6'd32;

   // Item action codes.
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 1'b0;
   localparam logic [ACTION_W-1:0] ACT_SCORE = 1'b1;

endpackage

`default_nettype wire

// ===== design/position_markov_sequence_scorer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A symbol item marked last reaches the result register through the read stage register.
// Throughput: one item (load or symbol) per cycle while req_stall is low, set by the single
// table RAM port pair and the one accumulate add that follows the registered RAM read.
// Reset (synchronous, active high) clears the context word, position count, score and all
// valid flags, and sets model_order to 2 and model_length to 32.
// The log table itself is not cleared; entries hold garbage until loaded.

module position_markov_sequence_scorer_unit #(
   parameter int MAX_LENGTH = pms_pkg::MAX_LENGTH_DEFAULT,
   parameter int MAX_ORDER  = pms_pkg::MAX_ORDER_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // Item channel
   input  wire logic                                    req_valid,
   output      logic                                    req_stall,
   input  wire logic [pms_pkg::ACTION_W-1:0]            req_action,
   input  wire logic [pms_pkg::POSITION_W-1:0]          req_table_position,
   input  wire logic [pms_pkg::WORD_W-1:0]              req_table_word,
   input  wire logic signed [pms_pkg::LOG_W-1:0]        req_log_prob,
   input  wire logic [pms_pkg::SYMBOL_W-1:0]            req_symbol,
   input  wire logic                                    req_last,
   // Result channel
   output      logic                                    rsp_valid,
   input  wire logic                                    rsp_stall,
   output      logic signed [pms_pkg::SCORE_W-1:0]      rsp_score,
   output      logic [pms_pkg::COUNT_W-1:0]             rsp_symbols_scored,
   // Control register write channel
   input  wire logic                                    csr_valid,
   output      logic                                    csr_ready,
   input  wire logic [pms_pkg::CSR_IDX_W-1:0]           csr_index,
   input  wire logic [pms_pkg::CSR_DATA_W-1:0]          csr_data
);

   import pms_pkg::*;

   // Derived dimensions.
   localparam int WB          = SYMBOL_BITS * (MAX_ORDER + 1);
   localparam int POS_W       = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int CNT_W       = $clog2(MAX_LENGTH + 1);
   localparam int LEN_W       = (CNT_W > LENGTH_W) ? CNT_W : LENGTH_W;
   localparam int OUT_W       = (LEN_W > COUNT_W) ? LEN_W : COUNT_W;
   localparam int LWORD_W     = (WB > WORD_W) ? WB : WORD_W;
   localparam int LPOS_W      = (POS_W > POSITION_W) ? POS_W : POSITION_W;
   localparam int ADDR_W      = POS_W + WB;
   localparam int TABLE_DEPTH = MAX_LENGTH * (2 ** WB);

   // Control registers.
   logic [ORDER_W-1:0]  order_ff;
   logic [LENGTH_W-1:0] length_ff;

   // Sequence state.
   logic [WB-1:0]       ctx_ff, ctx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;

   // Read stage registers.
   logic                s2_valid_ff, s2_valid_in;
   logic                s2_scored_ff;
   logic                s2_last_ff;
   logic [CNT_W-1:0]    s2_count_ff;
   logic signed [LOG_W-1:0] rdata_ff;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [SCORE_W-1:0] rsp_score_ff;
   logic [CNT_W-1:0]    rsp_count_ff;

   // Table storage.
   logic [LOG_W-1:0]    table_mem [0:TABLE_DEPTH-1];

   logic                req_fire, score_fire, load_fire, load_ok;
   logic                s2_stall, s2_fire;
   logic                in_range;
   logic [ORDER_W-1:0]  ord_eff;
   logic [LEN_W-1:0]    len_eff, count_wide;
   logic [WB-1:0]       word_mask, word_shift, word_next;
   logic [CNT_W-1:0]    count_inc;
   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic [LWORD_W-1:0]  load_word_wide;
   logic [LPOS_W-1:0]   load_pos_wide;
   logic signed [SCORE_W:0] sum_wide;
   logic signed [SCORE_W-1:0] sum_sat, score_next;
   logic [OUT_W-1:0]    out_count_wide;

   // Handshakes. The read stage only blocks when it holds a result and the
   // result register is full and stalled.
   assign s2_stall   = s2_valid_ff && s2_last_ff && rsp_valid_ff && rsp_stall;
   assign s2_fire    = s2_valid_ff && !s2_stall;
   assign req_stall  = s2_stall;
   assign req_fire   = req_valid && !req_stall;
   assign score_fire = req_fire && (req_action == ACT_SCORE);
   assign load_fire  = req_fire && (req_action == ACT_LOAD);
   assign csr_ready  = 1'b1;

   // Effective order and length, clamped to the built table size.
   assign ord_eff    = (int'(order_ff) > MAX_ORDER) ? ORDER_W'(MAX_ORDER) : order_ff;
   assign len_eff    = (int'(length_ff) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH)
                                                       : LEN_W'(length_ff);
   assign count_wide = LEN_W'(count_ff);
   assign in_range   = count_wide < len_eff;
   assign count_inc  = count_ff + CNT_W'(1);

   // Keep min(position, order) + 1 symbols of the shifted context.
   always_comb begin
      word_mask = '0;
      for (int i = 0; i <= MAX_ORDER; i++) begin
         if ((i <= int'(ord_eff)) && (i <= int'(count_ff))) begin
            word_mask[i*SYMBOL_BITS +: SYMBOL_BITS] = '1;
         end
      end
   end

   assign word_shift = (ctx_ff << SYMBOL_BITS) | WB'(req_symbol);
   assign word_next  = word_shift & word_mask;
   assign rd_addr    = {count_ff[POS_W-1:0], word_next};

   // Load address: the word and position are widened before trimming to the table.
   assign load_word_wide = LWORD_W'(req_table_word);
   assign load_pos_wide  = LPOS_W'(req_table_position);
   assign wr_addr        = {load_pos_wide[POS_W-1:0], load_word_wide[WB-1:0]};
   assign load_ok        = load_fire && (int'(req_table_position) < MAX_LENGTH);

   // Table write on load, registered read on every symbol item.
   always_ff @(posedge clock) begin
      if (load_ok) begin
         table_mem[wr_addr] <= req_log_prob;
      end
      if (score_fire) begin
         rdata_ff <= table_mem[rd_addr];
      end
   end

   // Context and position update at accept; the last item clears them.
   always_comb begin
      ctx_in   = ctx_ff;
      count_in = count_ff;
      if (score_fire) begin
         if (in_range) begin
            ctx_in   = word_next;
            count_in = count_inc;
         end
         if (req_last) begin
            ctx_in   = '0;
            count_in = '0;
         end
      end
   end

   // Accumulate with saturation to the score range.
   assign sum_wide = (SCORE_W+1)'(score_ff) + (SCORE_W+1)'(rdata_ff);

   always_comb begin
      if (sum_wide[SCORE_W] != sum_wide[SCORE_W-1]) begin
         sum_sat = sum_wide[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
                                     : {1'b0, {(SCORE_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SCORE_W-1:0];
      end
   end

   assign score_next = s2_scored_ff ? sum_sat : score_ff;

   always_comb begin
      score_in = score_ff;
      if (s2_fire) begin
         score_in = s2_last_ff ? '0 : score_next;
      end
   end

   // Read stage and result register valid flags.
   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (score_fire) begin
         s2_valid_in = 1'b1;
      end else if (s2_fire) begin
         s2_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s2_fire && s2_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff     <= ORDER_RESET;
         length_ff    <= LENGTH_RESET;
         ctx_ff       <= '0;
         count_ff     <= '0;
         score_ff     <= '0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ORDER: begin
                  order_ff <= csr_data[ORDER_W-1:0];
               end
               CSR_LENGTH: begin
                  length_ff <= csr_data[LENGTH_W-1:0];
               end
               default: begin
               end
            endcase
         end
         ctx_ff       <= ctx_in;
         count_ff     <= count_in;
         score_ff     <= score_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (score_fire) begin
         s2_scored_ff <= in_range;
         s2_last_ff   <= req_last;
         s2_count_ff  <= in_range ? count_inc : count_ff;
      end
      if (s2_fire && s2_last_ff) begin
         rsp_score_ff <= score_next;
         rsp_count_ff <= s2_count_ff;
      end
   end

   // Outputs.
   assign out_count_wide     = OUT_W'(rsp_count_ff);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_score          = rsp_score_ff;
   assign rsp_symbols_scored = out_count_wide[COUNT_W-1:0];

endmodule

`default_nettype wire

// ===== design/pms_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pms_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_stall,
   input wire logic [pms_pkg::ACTION_W-1:0]       req_action,
   input wire logic                               req_last,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic [pms_pkg::COUNT_W-1:0]        rsp_symbols_scored
);

   import pms_pkg::*;

   // A result stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // Items are held off only behind a stalled, full result register.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("item stalled without a waiting result");

   // A fresh result must trace back to an accepted last symbol item.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && !req_stall && (req_action == ACT_SCORE) && req_last, 2))
      else $error("result without a last symbol item");

   // The reported count never exceeds the model size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_symbols_scored) <= MAX_LENGTH_DEFAULT))
      else $error("symbol count out of range");

   // The result channel is empty right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind position_markov_sequence_scorer_unit pms_checker u_pms_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_action         (req_action),
   .req_last           (req_last),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_symbols_scored (rsp_symbols_scored)
);

`default_nettype wire
